### src/bdq_pkg.sv
// Shared types and constants for the bounded deque.
// No dependencies; imported by bdq_cell and bounded_deque_with_remove.
package bdq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_REMOVE     = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Operation broadcast to every cell.
  typedef struct packed {
    logic              en;
    kind_e             kind;
    logic [DATA_W-1:0] value;
  } cmd_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic              vld;
    logic [DATA_W-1:0] data;
  } link_t;

endpackage

### src/bdq_cell.sv
// One entry slot of the deque chain: data, occupied flag, neighbor shifts.
// Depends on bdq_pkg.
module bdq_cell
  import bdq_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cmd_t  cmd_i,
  input  link_t left_i,   // cell toward the front (value/1 for the first cell)
  input  link_t right_i,  // cell toward the back (0 for the last cell)
  input  logic  hit_i,    // a match sits in a cell before this one
  output link_t self_o,
  output logic  hit_o,
  output logic  is_back_o
);

  logic              vld_q, vld_d;
  logic [DATA_W-1:0] data_q, data_d;
  logic              match;

  assign match     = vld_q && (data_q == cmd_i.value);
  assign hit_o     = hit_i || match;
  assign is_back_o = vld_q && !right_i.vld;
  assign self_o    = '{vld: vld_q, data: data_q};

  always_comb begin
    vld_d  = vld_q;
    data_d = data_q;
    if (cmd_i.en) begin
      case (cmd_i.kind)
        KIND_PUSH_FRONT: begin
          vld_d  = left_i.vld;
          data_d = left_i.data;
        end
        KIND_PUSH_BACK: begin
          if (!vld_q && left_i.vld) begin
            vld_d  = 1'b1;
            data_d = cmd_i.value;
          end
        end
        KIND_POP_FRONT: begin
          vld_d  = right_i.vld;
          data_d = right_i.data;
        end
        KIND_POP_BACK: begin
          if (is_back_o) vld_d = 1'b0;
        end
        KIND_REMOVE: begin
          // every cell from the first match on takes its right neighbor
          if (hit_o) begin
            vld_d  = right_i.vld;
            data_d = right_i.data;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

### src/bounded_deque_with_remove.sv
// Top level of the bounded deque: chain of bdq_cell slots plus handshake
// and result register. Depends on bdq_pkg and bdq_cell.
//
// Usage:
// - Input channel (in_valid_i / in_stall_o) carries one command word:
//   kind (push front, push back, pop front, pop back, remove value) and value.
// - Output channel (out_valid_o / out_stall_i) returns one result word per
//   command: status, entry count, front and back values after the command.
// - The state is a row of DEPTH cells; cell 0 is the front. Every cell
//   decides locally whether it keeps its word or takes a neighbor's, so
//   all five operations, remove included, update the queue at the accept edge.
//   The first-match flag ripples front to back through the cells.
// - Result: a command accepted at an edge updates the cells at that edge; the
//   result is computed from the new state and lands in the output register
//   once that register is free (out_valid_o high after it).
// - One command in flight: the pending result stage holds in_stall_o high
//   after an accept until its result is loaded into the output register.
// - Receiver stall: while the output word waits, in_stall_o stays high, so
//   no command is lost and no result is overwritten.
// - Reset (rst_ni low, async): queue empty, no result pending, output
//   invalid. Cell data registers are not reset; only occupied cells are read.
// - Push to a full queue is dropped (status full), pop on empty is ignored
//   (status empty), remove with no match leaves the queue (status not found).
module bounded_deque_with_remove
  import bdq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        in_kind_i,
  input  logic [DATA_W-1:0] in_value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        out_status_o,
  output logic [4:0]        out_count_o,
  output logic [DATA_W-1:0] out_front_value_o,
  output logic [DATA_W-1:0] out_back_value_o
);

  logic              accept;
  logic              pend_q;
  status_e           status_q, status_d;
  logic [CNT_W-1:0]  occ_q, occ_d;
  logic              out_vld_q;
  status_e           out_status_q;
  logic [CNT_W-1:0]  out_cnt_q;
  logic [DATA_W-1:0] out_front_q, out_back_q;
  logic              out_load;

  cmd_t              cmd;
  link_t             links [DEPTH];
  logic [DEPTH:0]    hit;
  logic [DEPTH-1:0]  is_back;
  logic [DEPTH-1:0]  vld_vec;
  logic              full, empty, found;
  logic [DATA_W-1:0] back_val;
  logic [CNT_W+4:0]  cnt_ext;
  kind_e             kind;

  // ---- handshake: one command in flight until its result is registered
  assign in_stall_o = pend_q || (out_vld_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_load   = pend_q && !(out_vld_q && out_stall_i);

  assign kind  = kind_e'(in_kind_i);
  assign full  = (occ_q == CNT_W'(DEPTH));
  assign empty = (occ_q == '0);
  assign found = hit[DEPTH];

  // ---- decide status, occupancy and whether the cells move
  always_comb begin
    status_d  = ST_DONE;
    occ_d     = occ_q;
    cmd.en    = 1'b0;
    cmd.kind  = kind;
    cmd.value = in_value_i;
    case (kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          cmd.en = accept;
          occ_d  = occ_q + CNT_W'(1);
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          cmd.en = accept;
          occ_d  = occ_q - CNT_W'(1);
        end
      end
      KIND_REMOVE: begin
        if (!found) begin
          status_d = ST_NOTFOUND;
        end else begin
          cmd.en = accept;
          occ_d  = occ_q - CNT_W'(1);
        end
      end
      default: ;  // unused codes: no change, status done
    endcase
  end

  // ---- the cell chain
  assign hit[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    link_t left_l, right_l;
    if (i == 0) begin : g_first
      assign left_l = '{vld: 1'b1, data: in_value_i};
    end else begin : g_mid_l
      assign left_l = links[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_l = '{vld: 1'b0, data: '0};
    end else begin : g_mid_r
      assign right_l = links[i+1];
    end

    bdq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .left_i    (left_l),
      .right_i   (right_l),
      .hit_i     (hit[i]),
      .self_o    (links[i]),
      .hit_o     (hit[i+1]),
      .is_back_o (is_back[i])
    );
    assign vld_vec[i] = links[i].vld;
  end

  // back value: exactly one cell flags itself as the back when non-empty
  always_comb begin
    back_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_val = back_val | (is_back[i] ? links[i].data : '0);
    end
  end

  // ---- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 1'b0;
      occ_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        pend_q <= 1'b1;
        occ_q  <= occ_d;
      end else if (out_load) begin
        pend_q <= 1'b0;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // ---- payload registers
  always_ff @(posedge clk_i) begin
    if (accept) status_q <= status_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_cnt_q    <= occ_q;
      out_front_q  <= links[0].vld ? links[0].data : '0;
      out_back_q   <= back_val;
    end
  end

  assign cnt_ext           = {5'd0, out_cnt_q};
  assign out_valid_o       = out_vld_q;
  assign out_status_o      = out_status_q;
  assign out_count_o       = cnt_ext[4:0];
  assign out_front_value_o = out_front_q;
  assign out_back_value_o  = out_back_q;

  // ---- assertions
  a_occ_matches_cells : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == CNT_W'($countones(vld_vec)))
    else $error("occupancy disagrees with occupied cells");

  a_cells_packed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld_vec + DEPTH'(1)) & vld_vec) == '0)
    else $error("occupied cells not packed at the front");

  a_no_accept_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> in_stall_o)
    else $error("command accepted with a result pending");

  a_full_unchanged : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && status_q == ST_FULL) |-> occ_q == CNT_W'(DEPTH))
    else $error("dropped push changed the queue");

  a_one_back : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(is_back))
    else $error("more than one back cell");

endmodule
